/* rtl/core/sensorless_motor_start_sequencer_top_assert.svh */
// Assertion macros used by the start sequencer checker.
`ifndef SENSORLESS_MOTOR_START_SEQUENCER_TOP_ASSERT_SVH
`define SENSORLESS_MOTOR_START_SEQUENCER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SMSS_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("smss: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SMSS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("smss: next-cycle check failed");

`endif

/* rtl/core/smss_pkg.sv */
// Types, codes and constants of the sensorless motor start sequencer.
`default_nettype none
package smss_pkg;

   typedef enum logic [2:0] {
      PH_STOP   = 3'd0,
      PH_OFFSET = 3'd1,
      PH_BSTART = 3'd2,
      PH_BWAIT  = 3'd3,
      PH_OSTART = 3'd4,
      PH_OWAIT  = 3'd5,
      PH_RAMP   = 3'd6,
      PH_RUN    = 3'd7
   } phase_type;

   typedef enum logic [2:0] {
      CSR_START_CURRENT    = 3'd0,
      CSR_ORIENT_VOLTAGE   = 3'd1,
      CSR_ORIENT_TICKS     = 3'd2,
      CSR_BOOST_TICKS      = 3'd3,
      CSR_ACCEL_STEP       = 3'd4,
      CSR_ACCEL_LIMIT      = 3'd5,
      CSR_SPEED_LIMIT      = 3'd6,
      CSR_TICKS_PER_SECOND = 3'd7
   } csr_index_type;

   localparam logic [1:0] PWM_OFF      = 2'd0;
   localparam logic [1:0] PWM_LOW_SIDE = 2'd1;
   localparam logic [1:0] PWM_SIX      = 2'd2;

   localparam logic [2:0] LED_IDLE      = 3'd0;
   localparam logic [2:0] LED_RAMP_DONE = 3'd1;
   localparam logic [2:0] LED_RUNNING   = 3'd2;
   localparam logic [2:0] LED_FAULT     = 3'd4;

   localparam logic CMD_START = 1'b1;

   localparam int CSR_DATA_W = 16;

   localparam logic [15:0] BOOST_TICKS_RESET      = 16'd10000;
   localparam logic [15:0] SPEED_LIMIT_RESET      = 16'd874;
   localparam logic [15:0] TICKS_PER_SECOND_RESET = 16'd25000;

   localparam logic [1:0]         FAULT_LIMIT      = 2'd3;
   localparam logic [2:0]         HANDOVER_TICKS   = 3'd3;
   localparam logic signed [15:0] ANGLE_60         = 16'sd10923;
   localparam logic [15:0]        RAMP_START_ANGLE = 16'hC000;
   localparam logic [31:0]        SPEED_START      = 32'h0001_0000;
   localparam logic [31:0]        SECONDS_MAX      = 32'hFFFF_FFFF;

   typedef struct packed {
      logic signed [15:0] start_current;
      logic [14:0]        orient_voltage;
      logic [15:0]        orient_ticks;
      logic [15:0]        boost_ticks;
      logic [15:0]        accel_step;
      logic [15:0]        accel_limit;
      logic [15:0]        speed_limit;
      logic [15:0]        ticks_per_second;
   } cfg_type;

   typedef struct packed {
      logic               cmd;
      logic               break_fault;
      logic               offset_done;
      logic signed [15:0] pll_angle;
      logic [14:0]        drive_magnitude;
      logic signed [15:0] drive_angle_offset;
      logic signed [15:0] target_current;
   } item_type;

   typedef struct packed {
      logic [2:0]         phase;
      logic [1:0]         pwm_mode;
      logic [14:0]        voltage_out;
      logic signed [15:0] voltage_angle;
      logic               voltage_valid;
      logic signed [15:0] transform_angle;
      logic signed [15:0] current_command;
      logic [2:0]         led_code;
      logic               error_flag;
      logic [31:0]        run_seconds;
      logic               rearm_output;
      logic               calibrating;
   } result_type;

   typedef struct packed {
      phase_type   phase;
      logic [1:0]  fault_count;
      logic [15:0] wait_ticks;
      logic [15:0] second_ticks;
      logic [31:0] accel_accum;
      logic [31:0] speed_accum;
      logic [2:0]  handover_count;
      logic [15:0] angle_gap;
      logic [15:0] park_angle;
      logic [15:0] current_cmd;
      logic [31:0] seconds;
      logic [2:0]  led;
      logic        error;
   } state_type;

   function automatic logic [1:0] pwm_of(input phase_type ph);
      logic [1:0] mode;
      mode = PWM_OFF;
      if (ph == PH_BWAIT) begin
         mode = PWM_LOW_SIDE;
      end else if (ph == PH_OWAIT || ph == PH_RAMP || ph == PH_RUN) begin
         mode = PWM_SIX;
      end
      return mode;
   endfunction

endpackage
`default_nettype wire

/* rtl/core/smss_req_if.sv */
// Input item channel of the start sequencer.
`default_nettype none
interface smss_req_if;
   logic              valid;
   logic              ready;
   smss_pkg::item_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* rtl/core/smss_rsp_if.sv */
// Result item channel of the start sequencer.
`default_nettype none
interface smss_rsp_if;
   logic                valid;
   logic                ready;
   smss_pkg::result_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* rtl/core/smss_csr.sv */
// Configuration register file of the start sequencer.
`default_nettype none
module smss_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_write_enable,
   input  wire smss_pkg::csr_index_type         csr_index,
   input  wire logic [smss_pkg::CSR_DATA_W-1:0] csr_write_data,
   output smss_pkg::cfg_type                    cfg
);

   smss_pkg::cfg_type cfg_ff;
   smss_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            smss_pkg::CSR_START_CURRENT:    cfg_in.start_current    = csr_write_data;
            smss_pkg::CSR_ORIENT_VOLTAGE:   cfg_in.orient_voltage   = csr_write_data[14:0];
            smss_pkg::CSR_ORIENT_TICKS:     cfg_in.orient_ticks     = csr_write_data;
            smss_pkg::CSR_BOOST_TICKS:      cfg_in.boost_ticks      = csr_write_data;
            smss_pkg::CSR_ACCEL_STEP:       cfg_in.accel_step       = csr_write_data;
            smss_pkg::CSR_ACCEL_LIMIT:      cfg_in.accel_limit      = csr_write_data;
            smss_pkg::CSR_SPEED_LIMIT:      cfg_in.speed_limit      = csr_write_data;
            smss_pkg::CSR_TICKS_PER_SECOND: cfg_in.ticks_per_second = csr_write_data;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_current    <= '0;
         cfg_ff.orient_voltage   <= '0;
         cfg_ff.orient_ticks     <= '0;
         cfg_ff.boost_ticks      <= smss_pkg::BOOST_TICKS_RESET;
         cfg_ff.accel_step       <= '0;
         cfg_ff.accel_limit      <= '0;
         cfg_ff.speed_limit      <= smss_pkg::SPEED_LIMIT_RESET;
         cfg_ff.ticks_per_second <= smss_pkg::TICKS_PER_SECOND_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

/* rtl/core/smss_step.sv */
// Next-state and result logic for one item of the start sequencer.
`default_nettype none
module smss_step (
   input  wire smss_pkg::cfg_type    cfg,
   input  wire smss_pkg::state_type  cur,
   input  wire smss_pkg::item_type   item,
   output smss_pkg::state_type       nxt,
   output smss_pkg::result_type      res
);

   logic [1:0]  fault_inc;
   logic [15:0] wait_dec;

   logic [31:0] accel_n;
   logic [31:0] speed_sum;
   logic [31:0] speed_n;
   logic [15:0] spd_hi;
   logic [15:0] park_n;
   logic [15:0] gap_n;
   logic        gap_pos;
   logic        at_speed;
   logic [2:0]  hc_arm;
   logic [2:0]  hc_step;
   logic [2:0]  hc_ramp;
   logic        to_run;

   logic [15:0] cur_slew;
   logic [31:0] seconds_inc;

   logic [14:0] v_out;
   logic [15:0] v_ang;
   logic        v_valid;
   logic        rearm;
   logic        calib;

   assign fault_inc = cur.fault_count + 2'd1;
   assign wait_dec  = (cur.wait_ticks != 16'd0) ? cur.wait_ticks - 16'd1 : 16'd0;

   // Forced ramp: acceleration and speed integrators, each clamped.
   assign accel_n   = (cur.accel_accum[31:16] < cfg.accel_limit)
                    ? cur.accel_accum + {16'd0, cfg.accel_step}
                    : {cfg.accel_limit, cur.accel_accum[15:0]};
   assign speed_sum = cur.speed_accum + {4'd0, accel_n[31:4]};
   assign speed_n   = (speed_sum[31:16] >= cfg.speed_limit)
                    ? {cfg.speed_limit, speed_sum[15:0]} : speed_sum;
   assign spd_hi    = speed_n[31:16];
   assign park_n    = cur.park_angle + spd_hi;
   assign gap_n     = item.pll_angle - park_n;
   assign gap_pos   = $signed(gap_n) > 16'sd0;
   assign at_speed  = spd_hi >= cfg.speed_limit;

   assign hc_arm  = ($signed(park_n) > smss_pkg::ANGLE_60 && cur.handover_count == 3'd0)
                  ? 3'd1 : cur.handover_count;
   assign hc_step = gap_pos ? hc_arm + 3'd1 : 3'd1;
   assign hc_ramp = (hc_arm != 3'd0 && at_speed) ? hc_step : hc_arm;
   assign to_run  = hc_arm != 3'd0 && at_speed && gap_pos
                  && hc_step > smss_pkg::HANDOVER_TICKS;

   always_comb begin
      if ($signed(cur.current_cmd) < item.target_current) begin
         cur_slew = cur.current_cmd + 16'd1;
      end else if ($signed(cur.current_cmd) > item.target_current) begin
         cur_slew = cur.current_cmd - 16'd1;
      end else begin
         cur_slew = cur.current_cmd;
      end
   end

   assign seconds_inc = (cur.seconds != smss_pkg::SECONDS_MAX)
                      ? cur.seconds + 32'd1 : cur.seconds;

   always_comb begin
      nxt     = cur;
      v_out   = '0;
      v_ang   = '0;
      v_valid = 1'b0;
      rearm   = 1'b0;
      calib   = 1'b0;
      if (item.cmd == smss_pkg::CMD_START) begin
         if (cur.phase == smss_pkg::PH_STOP) begin
            nxt.phase = smss_pkg::PH_OFFSET;
            nxt.error = 1'b0;
         end
      end else begin
         nxt.wait_ticks = wait_dec;
         if (item.break_fault) begin
            if (fault_inc == smss_pkg::FAULT_LIMIT) begin
               nxt.fault_count = '0;
               nxt.led         = smss_pkg::LED_FAULT;
               nxt.phase       = smss_pkg::PH_STOP;
               nxt.error       = 1'b1;
               nxt.seconds     = '0;
            end else begin
               nxt.fault_count = fault_inc;
               rearm           = 1'b1;
            end
         end else begin
            nxt.fault_count = '0;
            unique case (cur.phase)
               smss_pkg::PH_STOP: begin
                  nxt.led     = smss_pkg::LED_IDLE;
                  nxt.seconds = '0;
                  calib       = !cur.error;
               end
               smss_pkg::PH_OFFSET: begin
                  if (!item.offset_done) begin
                     calib = 1'b1;
                  end else begin
                     nxt.phase        = smss_pkg::PH_BSTART;
                     nxt.seconds      = '0;
                     nxt.second_ticks = cfg.ticks_per_second;
                  end
               end
               smss_pkg::PH_BSTART: begin
                  nxt.wait_ticks = cfg.boost_ticks;
                  nxt.phase      = smss_pkg::PH_BWAIT;
               end
               smss_pkg::PH_BWAIT: begin
                  if (wait_dec == 16'd0) begin
                     nxt.phase = smss_pkg::PH_OSTART;
                  end
               end
               smss_pkg::PH_OSTART: begin
                  v_out          = cfg.orient_voltage;
                  v_valid        = 1'b1;
                  nxt.wait_ticks = cfg.orient_ticks;
                  nxt.phase      = smss_pkg::PH_OWAIT;
               end
               smss_pkg::PH_OWAIT: begin
                  if (wait_dec == 16'd0) begin
                     nxt.current_cmd    = cfg.start_current;
                     nxt.handover_count = '0;
                     nxt.accel_accum    = '0;
                     nxt.speed_accum    = smss_pkg::SPEED_START;
                     nxt.park_angle     = smss_pkg::RAMP_START_ANGLE;
                     nxt.phase          = smss_pkg::PH_RAMP;
                  end
               end
               smss_pkg::PH_RAMP: begin
                  nxt.accel_accum    = accel_n;
                  nxt.speed_accum    = speed_n;
                  nxt.park_angle     = park_n;
                  nxt.angle_gap      = gap_n;
                  nxt.handover_count = hc_ramp;
                  v_out              = item.drive_magnitude;
                  v_valid            = 1'b1;
                  v_ang              = park_n + item.drive_angle_offset;
                  if (to_run) begin
                     nxt.phase = smss_pkg::PH_RUN;
                     nxt.led   = smss_pkg::LED_RAMP_DONE;
                  end
               end
               smss_pkg::PH_RUN: begin
                  v_out          = item.drive_magnitude;
                  v_valid        = 1'b1;
                  v_ang          = cur.park_angle + item.drive_angle_offset;
                  nxt.park_angle = item.pll_angle - cur.angle_gap;
                  if ($signed(cur.angle_gap) < 16'sd0) begin
                     nxt.angle_gap = cur.angle_gap + 16'd1;
                  end else if ($signed(cur.angle_gap) > 16'sd0) begin
                     nxt.angle_gap = cur.angle_gap - 16'd1;
                  end else begin
                     if (cur.second_ticks == 16'd0) begin
                        nxt.second_ticks = cfg.ticks_per_second;
                        nxt.seconds      = seconds_inc;
                     end else begin
                        nxt.second_ticks = cur.second_ticks - 16'd1;
                     end
                     nxt.current_cmd = cur_slew;
                     nxt.led         = smss_pkg::LED_RUNNING;
                  end
               end
               default: nxt.phase = smss_pkg::PH_STOP;
            endcase
         end
      end
   end

   always_comb begin
      res.phase           = nxt.phase;
      res.pwm_mode        = smss_pkg::pwm_of(nxt.phase);
      res.voltage_out     = v_out;
      res.voltage_angle   = v_ang;
      res.voltage_valid   = v_valid;
      res.transform_angle = nxt.park_angle;
      res.current_command = nxt.current_cmd;
      res.led_code        = nxt.led;
      res.error_flag      = nxt.error;
      res.run_seconds     = nxt.seconds;
      res.rearm_output    = rearm;
      res.calibrating     = calib;
   end

endmodule
`default_nettype wire

/* rtl/core/sensorless_motor_start_sequencer_top.sv */
// Top level of the sensorless motor start sequencer.
//
//   channel   direction  handshake            content
//   req_bus   in         valid/ready          one control tick or start request
//   rsp_bus   out        valid/ready          one command item per request item
//   csr_*     in         write enable only    eight configuration registers
//
// An item is registered at the input, processed against the phase state and written
// to the result register; one item per cycle is sustained while results are taken.
// Reset is synchronous; it resets the phase state, the configuration (to its defaults) and both valids.
// A stalled result holds the result register; the input register still takes
// one item, and further items wait until the result is taken.
`default_nettype none
module sensorless_motor_start_sequencer_top (
   input  wire logic                            clock,
   input  wire logic                            reset,
   smss_req_if.sink                             req_bus,
   smss_rsp_if.source                           rsp_bus,
   input  wire logic                            csr_write_enable,
   input  wire smss_pkg::csr_index_type         csr_index,
   input  wire logic [smss_pkg::CSR_DATA_W-1:0] csr_write_data
);

   smss_pkg::cfg_type    cfg;
   smss_pkg::item_type   item_ff;
   logic                 item_valid_ff;
   smss_pkg::state_type  state_ff;
   smss_pkg::state_type  state_in;
   smss_pkg::result_type result_in;
   smss_pkg::result_type rsp_ff;
   logic                 rsp_valid_ff;
   logic                 out_free;
   logic                 advance;
   logic                 req_take;

   smss_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   smss_step u_step (
      .cfg  (cfg),
      .cur  (state_ff),
      .item (item_ff),
      .nxt  (state_in),
      .res  (result_in)
   );

   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign advance       = item_valid_ff && out_free;
   assign req_bus.ready = !item_valid_ff || out_free;
   assign req_take      = req_bus.valid && req_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_take) begin
         item_valid_ff <= 1'b1;
      end else if (advance) begin
         item_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= req_bus.payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase          <= smss_pkg::PH_STOP;
         state_ff.fault_count    <= '0;
         state_ff.wait_ticks     <= '0;
         state_ff.second_ticks   <= '0;
         state_ff.accel_accum    <= '0;
         state_ff.speed_accum    <= '0;
         state_ff.handover_count <= '0;
         state_ff.angle_gap      <= '0;
         state_ff.park_angle     <= '0;
         state_ff.current_cmd    <= '0;
         state_ff.seconds        <= '0;
         state_ff.led            <= '0;
         state_ff.error          <= 1'b0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result_in;
      end
   end

   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.payload = rsp_ff;

endmodule
`default_nettype wire

/* rtl/core/smss_checker.sv */
// Port-level checker of the start sequencer and its bind to the top level.
`default_nettype none
`include "sensorless_motor_start_sequencer_top_assert.svh"
module smss_checker (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire smss_pkg::result_type rsp_payload
);

   `SMSS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))
   `SMSS_ASSERT_SAME(a_idle_modulator, clock, reset, rsp_valid && !rsp_payload.voltage_valid, rsp_payload.voltage_out == 15'd0 && rsp_payload.voltage_angle == 16'sd0)
   `SMSS_ASSERT_SAME(a_error_stops, clock, reset, rsp_valid && rsp_payload.error_flag, rsp_payload.phase == smss_pkg::PH_STOP)
   `SMSS_ASSERT_SAME(a_pwm_phase, clock, reset, rsp_valid, ((rsp_payload.pwm_mode == smss_pkg::PWM_LOW_SIDE) == (rsp_payload.phase == smss_pkg::PH_BWAIT)) && ((rsp_payload.pwm_mode == smss_pkg::PWM_SIX) == (rsp_payload.phase == smss_pkg::PH_OWAIT || rsp_payload.phase == smss_pkg::PH_RAMP || rsp_payload.phase == smss_pkg::PH_RUN)))
   `SMSS_ASSERT_SAME(a_no_drive_when_rearm, clock, reset, rsp_valid && (rsp_payload.rearm_output || rsp_payload.calibrating), !rsp_payload.voltage_valid)

endmodule

bind sensorless_motor_start_sequencer_top smss_checker u_smss_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .rsp_payload (rsp_bus.payload)
);
`default_nettype wire

/* tb/tb_sensorless_motor_start_sequencer_top.sv */
// Self-checking testbench for the start sequencer, with its own command predictor.
module tb_sensorless_motor_start_sequencer_top;
   import smss_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 6;
   localparam int IDLE_PERCENT  = 8;

   typedef enum {SETUP_TUNED, SETUP_FLOOR, SETUP_CEILING, SETUP_WILD} setup_kind;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_write_enable;
   csr_index_type         csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   smss_req_if req_if();
   smss_rsp_if rsp_if();

   cfg_type     cfg;
   state_type   seq;
   result_type  expected_commands[$];
   int unsigned failures = 0;
   int unsigned items_sent = 0;
   int unsigned cycle_count = 0;
   int          receiver_hold = 0;
   bit          steady = 1'b0;

   sensorless_motor_start_sequencer_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_if),
      .rsp_bus          (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** sensorless_motor_start_sequencer_top: FAILED **");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (receiver_hold > 0) begin
         rsp_if.ready <= 1'b0;
         receiver_hold--;
      end else begin
         rsp_if.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_commands.size() == 0) begin
            $error("result item arrived with no command expected");
            failures++;
         end else begin
            want = expected_commands.pop_front();
            check_field("phase", want.phase, rsp_if.payload.phase);
            check_field("pwm_mode", want.pwm_mode, rsp_if.payload.pwm_mode);
            check_field("voltage_out", want.voltage_out, rsp_if.payload.voltage_out);
            check_field("voltage_angle", want.voltage_angle, rsp_if.payload.voltage_angle);
            check_field("voltage_valid", want.voltage_valid, rsp_if.payload.voltage_valid);
            check_field("transform_angle", want.transform_angle,
                        rsp_if.payload.transform_angle);
            check_field("current_command", want.current_command,
                        rsp_if.payload.current_command);
            check_field("led_code", want.led_code, rsp_if.payload.led_code);
            check_field("error_flag", want.error_flag, rsp_if.payload.error_flag);
            check_field("run_seconds", want.run_seconds, rsp_if.payload.run_seconds);
            check_field("rearm_output", want.rearm_output, rsp_if.payload.rearm_output);
            check_field("calibrating", want.calibrating, rsp_if.payload.calibrating);
         end
      end
   end

   function automatic logic [1:0] drive_mode(input phase_type ph);
      case (ph)
         PH_BWAIT:                 drive_mode = PWM_LOW_SIDE;
         PH_OWAIT, PH_RAMP, PH_RUN: drive_mode = PWM_SIX;
         default:                  drive_mode = PWM_OFF;
      endcase
   endfunction

   task automatic reset_sequencer_model();
      seq = '0;
      seq.phase = PH_STOP;
      cfg = '0;
      cfg.boost_ticks = BOOST_TICKS_RESET;
      cfg.speed_limit = SPEED_LIMIT_RESET;
      cfg.ticks_per_second = TICKS_PER_SECOND_RESET;
   endtask

   task automatic advance_sequencer(input item_type it, output result_type res);
      logic [15:0]        spd_hi;
      logic signed [15:0] gap;
      res = '0;
      if (it.cmd == CMD_START) begin
         if (seq.phase == PH_STOP) begin
            seq.phase = PH_OFFSET;
            seq.error = 1'b0;
         end
      end else begin
         if (seq.wait_ticks != 0) seq.wait_ticks--;
         if (it.break_fault) begin
            seq.fault_count = seq.fault_count + 2'd1;
            if (seq.fault_count == FAULT_LIMIT) begin
               seq.fault_count = '0;
               seq.led = LED_FAULT;
               seq.phase = PH_STOP;
               seq.error = 1'b1;
               seq.seconds = '0;
            end else begin
               res.rearm_output = 1'b1;
            end
         end else begin
            seq.fault_count = '0;
            case (seq.phase)
               PH_STOP: begin
                  seq.led = LED_IDLE;
                  seq.seconds = '0;
                  res.calibrating = !seq.error;
               end
               PH_OFFSET: begin
                  if (!it.offset_done) begin
                     res.calibrating = 1'b1;
                  end else begin
                     seq.phase = PH_BSTART;
                     seq.seconds = '0;
                     seq.second_ticks = cfg.ticks_per_second;
                  end
               end
               PH_BSTART: begin
                  seq.wait_ticks = cfg.boost_ticks;
                  seq.phase = PH_BWAIT;
               end
               PH_BWAIT: begin
                  if (seq.wait_ticks == 0) seq.phase = PH_OSTART;
               end
               PH_OSTART: begin
                  res.voltage_out = cfg.orient_voltage;
                  res.voltage_valid = 1'b1;
                  seq.wait_ticks = cfg.orient_ticks;
                  seq.phase = PH_OWAIT;
               end
               PH_OWAIT: begin
                  if (seq.wait_ticks == 0) begin
                     seq.current_cmd = cfg.start_current;
                     seq.handover_count = '0;
                     seq.accel_accum = '0;
                     seq.speed_accum = SPEED_START;
                     seq.park_angle = RAMP_START_ANGLE;
                     seq.phase = PH_RAMP;
                  end
               end
               PH_RAMP: begin
                  if (seq.accel_accum[31:16] < cfg.accel_limit) begin
                     seq.accel_accum = seq.accel_accum + {16'd0, cfg.accel_step};
                  end else begin
                     seq.accel_accum[31:16] = cfg.accel_limit;
                  end
                  seq.speed_accum = seq.speed_accum + (seq.accel_accum >> 4);
                  if (seq.speed_accum[31:16] >= cfg.speed_limit) begin
                     seq.speed_accum[31:16] = cfg.speed_limit;
                  end
                  spd_hi = seq.speed_accum[31:16];
                  seq.park_angle = seq.park_angle + spd_hi;
                  seq.angle_gap = it.pll_angle - seq.park_angle;
                  res.voltage_out = it.drive_magnitude;
                  res.voltage_valid = 1'b1;
                  res.voltage_angle = seq.park_angle + it.drive_angle_offset;
                  if ($signed(seq.park_angle) > ANGLE_60 && seq.handover_count == 0) begin
                     seq.handover_count = 3'd1;
                  end
                  if (seq.handover_count != 0 && spd_hi >= cfg.speed_limit) begin
                     if ($signed(seq.angle_gap) > 0) begin
                        seq.handover_count++;
                        if (seq.handover_count > HANDOVER_TICKS) begin
                           seq.phase = PH_RUN;
                           seq.led = LED_RAMP_DONE;
                        end
                     end else begin
                        seq.handover_count = 3'd1;
                     end
                  end
               end
               PH_RUN: begin
                  gap = seq.angle_gap;
                  res.voltage_out = it.drive_magnitude;
                  res.voltage_valid = 1'b1;
                  res.voltage_angle = seq.park_angle + it.drive_angle_offset;
                  seq.park_angle = it.pll_angle - seq.angle_gap;
                  if (gap < 0) begin
                     seq.angle_gap++;
                  end else if (gap > 0) begin
                     seq.angle_gap--;
                  end else begin
                     if (seq.second_ticks == 0) begin
                        seq.second_ticks = cfg.ticks_per_second;
                        if (seq.seconds != SECONDS_MAX) seq.seconds++;
                     end else begin
                        seq.second_ticks--;
                     end
                     if ($signed(seq.current_cmd) < it.target_current) begin
                        seq.current_cmd++;
                     end else if ($signed(seq.current_cmd) > it.target_current) begin
                        seq.current_cmd--;
                     end
                     seq.led = LED_RUNNING;
                  end
               end
               default: seq.phase = PH_STOP;
            endcase
         end
      end
      res.phase = seq.phase;
      res.pwm_mode = drive_mode(seq.phase);
      res.transform_angle = seq.park_angle;
      res.current_command = seq.current_cmd;
      res.led_code = seq.led;
      res.error_flag = seq.error;
      res.run_seconds = seq.seconds;
   endtask

   task automatic send_item(input item_type it);
      result_type want;
      if (!steady && $urandom_range(99) < IDLE_PERCENT) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.payload <= it;
      do @(posedge clock); while (!req_if.ready);
      advance_sequencer(it, want);
      expected_commands.push_back(want);
      items_sent++;
   endtask

   task automatic wait_for_results();
      req_if.valid <= 1'b0;
      while (expected_commands.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [15:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      case (idx)
         CSR_START_CURRENT:    cfg.start_current = data;
         CSR_ORIENT_VOLTAGE:   cfg.orient_voltage = data[14:0];
         CSR_ORIENT_TICKS:     cfg.orient_ticks = data;
         CSR_BOOST_TICKS:      cfg.boost_ticks = data;
         CSR_ACCEL_STEP:       cfg.accel_step = data;
         CSR_ACCEL_LIMIT:      cfg.accel_limit = data;
         CSR_SPEED_LIMIT:      cfg.speed_limit = data;
         CSR_TICKS_PER_SECOND: cfg.ticks_per_second = data;
         default: ;
      endcase
   endtask

   task automatic load_config(input cfg_type c);
      write_reg(CSR_START_CURRENT, c.start_current);
      write_reg(CSR_ORIENT_VOLTAGE, {1'($urandom), c.orient_voltage});
      write_reg(CSR_ORIENT_TICKS, c.orient_ticks);
      write_reg(CSR_BOOST_TICKS, c.boost_ticks);
      write_reg(CSR_ACCEL_STEP, c.accel_step);
      write_reg(CSR_ACCEL_LIMIT, c.accel_limit);
      write_reg(CSR_SPEED_LIMIT, c.speed_limit);
      write_reg(CSR_TICKS_PER_SECOND, c.ticks_per_second);
      csr_write_enable <= 1'b0;
   endtask

   function automatic cfg_type make_config(input setup_kind kind);
      cfg_type c;
      c.start_current    = 16'($urandom);
      c.orient_voltage   = 15'($urandom);
      c.orient_ticks     = 16'($urandom);
      c.boost_ticks      = 16'($urandom);
      c.accel_step       = 16'($urandom);
      c.accel_limit      = 16'($urandom);
      c.speed_limit      = 16'($urandom);
      c.ticks_per_second = 16'($urandom);
      case (kind)
         SETUP_TUNED: begin
            c.orient_ticks     = 16'($urandom_range(0, 6));
            c.boost_ticks      = 16'($urandom_range(0, 6));
            c.accel_step       = 16'($urandom_range(49152, 65535));
            c.accel_limit      = 16'($urandom_range(200, 600));
            c.speed_limit      = 16'($urandom_range(400, 1000));
            c.ticks_per_second = 16'($urandom_range(0, 4));
         end
         SETUP_FLOOR: begin
            c = '0;
            c.start_current = 16'sh8000;
         end
         SETUP_CEILING: begin
            c = '1;
            c.start_current = 16'sh7fff;
         end
         default: begin
            if ($urandom_range(1) == 1) begin
               c.orient_ticks = 16'($urandom_range(0, 20));
               c.boost_ticks  = 16'($urandom_range(0, 20));
            end
         end
      endcase
      return c;
   endfunction

   function automatic item_type random_item();
      item_type it;
      it.cmd                = 1'($urandom);
      it.break_fault        = 1'($urandom);
      it.offset_done        = 1'($urandom);
      it.pll_angle          = 16'($urandom);
      it.drive_magnitude    = 15'($urandom);
      it.drive_angle_offset = 16'($urandom);
      it.target_current     = 16'($urandom);
      return it;
   endfunction

   function automatic item_type noise_item();
      item_type it;
      it = random_item();
      it.cmd = ($urandom_range(99) < 15) ? CMD_START : ~CMD_START;
      it.break_fault = ($urandom_range(99) < 25);
      return it;
   endfunction

   // Picks the next item of a start-up run from the predicted phase; at full ramp
   // speed with the handover count armed, the PLL angle is mostly placed just ahead of the forced angle.
   function automatic item_type next_start_item();
      item_type it;
      it = random_item();
      it.cmd = ~CMD_START;
      it.break_fault = ($urandom_range(99) < 2);
      it.offset_done = ($urandom_range(99) < 40);
      if ($urandom_range(99) < 70) begin
         it.target_current = seq.current_cmd + 16'($urandom_range(0, 8)) - 16'd4;
      end
      case (seq.phase)
         PH_STOP: begin
            it.cmd = CMD_START;
            it.break_fault = 1'b0;
         end
         PH_RAMP: begin
            if (seq.handover_count != 0 && seq.speed_accum[31:16] == cfg.speed_limit &&
                $urandom_range(99) < 90) begin
               it.pll_angle = seq.park_angle + cfg.speed_limit + 16'($urandom_range(1, 40));
            end
         end
         default: begin
            if ($urandom_range(99) < 3) it.cmd = CMD_START;
         end
      endcase
      return it;
   endfunction

   task automatic drive_start_sequence(input int run_ticks, input int max_ticks,
                                       output bit reached_run);
      item_type it;
      int       ticks;
      int       in_run;
      ticks = 0;
      in_run = 0;
      while (ticks < max_ticks && in_run < run_ticks) begin
         send_item(next_start_item());
         ticks++;
         if (seq.phase == PH_RUN) in_run++;
      end
      reached_run = (in_run != 0);
      it = random_item();
      it.cmd = ~CMD_START;
      it.break_fault = 1'b1;
      repeat (3) send_item(it);
   endtask

   task automatic test_stop_and_start();
      item_type it;
      it = '1;
      it.cmd = ~CMD_START;
      it.break_fault = 1'b0;
      it.pll_angle = 16'sh7fff;
      it.drive_angle_offset = 16'sh7fff;
      it.target_current = 16'sh7fff;
      send_item(it);
      it = '0;
      it.pll_angle = 16'sh8000;
      it.drive_angle_offset = 16'sh8000;
      it.target_current = 16'sh8000;
      send_item(it);
      it.cmd = CMD_START;
      send_item(it);
      send_item(it);
      it.cmd = ~CMD_START;
      it.offset_done = 1'b0;
      send_item(it);
      it.offset_done = 1'b1;
      send_item(it);
      send_item(it);
   endtask

   task automatic test_break_faults();
      item_type it;
      it = random_item();
      it.cmd = ~CMD_START;
      it.break_fault = 1'b1;
      send_item(it);
      send_item(it);
      it.break_fault = 1'b0;
      send_item(it);
      it.break_fault = 1'b1;
      repeat (3) send_item(it);
      it.break_fault = 1'b0;
      send_item(it);
      it.cmd = CMD_START;
      send_item(it);
      it.cmd = ~CMD_START;
      it.break_fault = 1'b1;
      repeat (3) send_item(it);
   endtask

   task automatic test_backpressure();
      bit reached;
      wait_for_results();
      load_config(make_config(SETUP_TUNED));
      receiver_hold = 300;
      drive_start_sequence(40, 120, reached);
   endtask

   task automatic test_noise();
      wait_for_results();
      load_config(make_config(SETUP_WILD));
      repeat (100) send_item(noise_item());
   endtask

   task automatic test_random_starts();
      int unsigned first_item;
      int          runs;
      int          sequences;
      bit          reached;
      setup_kind   kind;
      first_item = items_sent;
      runs = 0;
      sequences = 0;
      while ((items_sent - first_item < 250 || runs < 1) && sequences < 24) begin
         case (sequences)
            0:       kind = SETUP_FLOOR;
            1:       kind = SETUP_CEILING;
            2:       kind = SETUP_TUNED;
            default: kind = ($urandom_range(99) < 75) ? SETUP_TUNED : SETUP_WILD;
         endcase
         wait_for_results();
         steady = (sequences == 2);
         load_config(make_config(kind));
         drive_start_sequence($urandom_range(30, 90), (kind == SETUP_TUNED) ? 450 : 40,
                              reached);
         if (reached) runs++;
         sequences++;
      end
      steady = 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      rsp_if.ready = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = CSR_START_CURRENT;
      csr_write_data = '0;
      reset_sequencer_model();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_stop_and_start();
      test_break_faults();
      test_backpressure();
      test_noise();
      test_random_starts();
      wait_for_results();
      if (failures == 0) begin
         $display("** sensorless_motor_start_sequencer_top: PASSED **");
      end else begin
         $display("** sensorless_motor_start_sequencer_top: FAILED **");
      end
      $finish;
   end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/smss_pkg.sv
rtl/core/smss_req_if.sv
rtl/core/smss_rsp_if.sv
rtl/core/smss_csr.sv
rtl/core/smss_step.sv
rtl/core/sensorless_motor_start_sequencer_top.sv
rtl/core/smss_checker.sv
tb/tb_sensorless_motor_start_sequencer_top.sv
